### rtl/srrc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes for the stream ring refill controller.
// No dependencies; every other file of the block imports this package.
package srrc_pkg;

	// Field widths
	localparam int OFF_W = 26;  // ring offsets and segment lengths
	localparam int SRC_W = 32;  // source byte positions
	localparam int BS_W  = 24;  // block size register
	localparam int CMD_W = 2;
	localparam int KIND_W = 2;
	localparam int CFG_W = 32;  // widest configuration register
	localparam int IDX_W = 2;   // configuration register index

	// Defaults
	localparam int BUFFER_BLOCKS_DEF = 4;
	localparam int BLOCK_SIZE_RST    = 705600;

	// Result queue depth (two entries per command plus skid room)
	localparam int FIFO_DEPTH = 4;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
	localparam logic [IDX_W-1:0] REG_LOOP_START = 2'd1;
	localparam logic [IDX_W-1:0] REG_LOOP_END   = 2'd2;

	// Segment kinds
	localparam logic [KIND_W-1:0] KIND_COPY    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SILENCE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_STOP    = 2'd2;

	// Command codes; CMD_NONE is accepted and ignored
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK = 2'd0,
		CMD_PLAY = 2'd1,
		CMD_STOP = 2'd2,
		CMD_NONE = 2'd3
	} cmd_e;

	// One result segment
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [OFF_W-1:0]  buffer_offset;
		logic [SRC_W-1:0]  source_offset;
		logic [OFF_W-1:0]  seg_length;
		logic              last;
	} res_t;

	// Core to result queue: number of segments produced this cycle and the segments
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

	// Remainder unit status
	typedef struct packed {
		logic             busy;
		logic             done;
		logic [OFF_W-1:0] rem;
	} rem_st_t;

endpackage

### rtl/srrc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the command and segment streams.
// Depends on srrc_pkg for field widths.
interface srrc_cmd_if import srrc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] cmd;
	logic [OFF_W-1:0] play_cursor;
	logic             restart;
	logic             loop_request;
	logic [SRC_W-1:0] start_byte;

	modport source(output valid, cmd, play_cursor, restart, loop_request, start_byte,
		input ready);
	modport sink(input valid, cmd, play_cursor, restart, loop_request, start_byte,
		output ready);
endinterface

interface srrc_seg_if import srrc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [OFF_W-1:0]  buffer_offset;
	logic [SRC_W-1:0]  source_offset;
	logic [OFF_W-1:0]  seg_length;
	logic              last;

	modport source(output valid, kind, buffer_offset, source_offset, seg_length, last,
		input ready);
	modport sink(input valid, kind, buffer_offset, source_offset, seg_length, last,
		output ready);
endinterface

### rtl/srrc_rem.sv
`timescale 1ns / 1ps
// Bit-serial restoring remainder: write cursor modulo ring size, one bit a cycle.
// Depends on srrc_pkg.
module srrc_rem import srrc_pkg::*; #(
	parameter int DIV_W = BS_W + 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [OFF_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output rem_st_t          st
);

	localparam int CW    = (OFF_W + 1 > DIV_W) ? OFF_W + 1 : DIV_W;
	localparam int CNT_W = $clog2(OFF_W + 1);

	logic             run_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [OFF_W-1:0] rem_q;
	logic [OFF_W-1:0] dvd_q;

	logic [CW-1:0]    trial;
	logic [CW-1:0]    diff;
	logic [OFF_W-1:0] rem_next;

	// One restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = CW'({rem_q, dvd_q[OFF_W-1]});
		diff  = trial - CW'(divisor);
		if (trial >= CW'(divisor)) begin
			rem_next = OFF_W'(diff);
		end else begin
			rem_next = OFF_W'(trial);
		end
	end

	// Sequencer; a new start restarts the pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(OFF_W);
		end else if (run_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (run_q) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[OFF_W-2:0], 1'b0};
		end
	end

	assign st.busy = run_q | done_q;
	assign st.done = done_q;
	assign st.rem  = rem_q;

endmodule

### rtl/srrc_fifo.sv
`timescale 1ns / 1ps
// Result queue: takes up to two segments a cycle, presents one a cycle while seg_ch is ready.
// Depends on srrc_pkg and srrc_if.
module srrc_fifo import srrc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  push_t       push,
	output logic        room,
	srrc_seg_if.source  seg_ch
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

	res_t             ent_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pop;
	res_t             head;

	assign pop  = seg_ch.valid && seg_ch.ready;
	assign room = cnt_q <= CNT_W'(FIFO_DEPTH - 2);

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	// Entry writes
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			ent_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			ent_q[wr_ptr_q + PTR_W'(1)] <= push.r1;
		end
	end

	assign head                 = ent_q[rd_ptr_q];
	assign seg_ch.valid         = cnt_q != '0;
	assign seg_ch.kind          = head.kind;
	assign seg_ch.buffer_offset = head.buffer_offset;
	assign seg_ch.source_offset = head.source_offset;
	assign seg_ch.seg_length    = head.seg_length;
	assign seg_ch.last          = head.last;

endmodule

### rtl/srrc_core.sv
`timescale 1ns / 1ps
// Command register, configuration and playback state, and the one-pass refill datapath.
// Depends on srrc_pkg and srrc_if.
module srrc_core import srrc_pkg::*; #(
	parameter int BUFFER_BLOCKS = BUFFER_BLOCKS_DEF,
	localparam int RING_W = BS_W + $clog2(BUFFER_BLOCKS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	srrc_cmd_if.sink          cmd_ch,
	input  logic              room,
	output push_t             push,
	output logic              rem_start,
	output logic [OFF_W-1:0]  rem_dividend,
	output logic [RING_W-1:0] ring,
	input  rem_st_t           rem_st
);

	localparam int CW = (RING_W > OFF_W) ? RING_W : OFF_W;
	localparam logic [RING_W-1:0] BB_C    = RING_W'(BUFFER_BLOCKS);
	localparam logic [RING_W-1:0] BB_M1_C = RING_W'(BUFFER_BLOCKS - 1);
	localparam logic [BS_W-1:0]   BS_RST  = BS_W'(BLOCK_SIZE_RST);
	localparam logic [RING_W-1:0] RING_RST = RING_W'(BUFFER_BLOCKS * BLOCK_SIZE_RST);
	localparam logic [RING_W-1:0] LIM_RST  = RING_W'((BUFFER_BLOCKS - 1) * BLOCK_SIZE_RST);

	// Configuration (block size kept as the effective, nonzero value)
	logic [BS_W-1:0]   b_q;
	logic [RING_W-1:0] ring_q;
	logic [RING_W-1:0] lim_q;
	logic [SRC_W-1:0]  ls_q;
	logic [SRC_W-1:0]  le_q;
	logic              rem_start_q;

	// Playback state; wm_q is write cursor modulo ring size
	logic [OFF_W-1:0] wc_q;
	logic [OFF_W-1:0] wm_q;
	logic [SRC_W-1:0] sp_q;
	logic             playing_q;
	logic             looping_q;
	logic             ended_q;

	// Command register
	logic             valid_s1;
	cmd_e             cmd_s1;
	logic [OFF_W-1:0] pc_s1;
	logic             restart_s1;
	logic             lreq_s1;
	logic [SRC_W-1:0] sb_s1;

	logic              busy;
	logic              proc;
	logic [BS_W-1:0]   b_new;
	logic [RING_W-1:0] ring_new;
	logic [RING_W-1:0] lim_new;

	// Datapath nets
	logic              do_restart;
	logic              ticking;
	logic              drain;
	logic              trig;
	logic              do_refill;
	logic [OFF_W-1:0]  at_off;
	logic [OFF_W-1:0]  at_mod;
	logic [RING_W-1:0] len;
	logic [SRC_W-1:0]  sp;
	logic              loop;
	logic              over;
	logic [SRC_W-1:0]  t32;
	logic [RING_W-1:0] t_r;
	logic [RING_W-1:0] rest;
	logic [RING_W:0]   sec_sum;
	logic [RING_W:0]   sec;
	logic [RING_W:0]   nsum;
	logic [RING_W:0]   nred;
	logic [OFF_W-1:0]  wc_next;
	logic [SRC_W-1:0]  sp_new;

	assign busy         = rem_start_q | rem_st.busy;
	assign proc         = valid_s1 && room && !busy;
	assign cmd_ch.ready = !busy && (!valid_s1 || proc);
	assign rem_start    = rem_start_q;
	assign rem_dividend = wc_q;
	assign ring         = ring_q;

	// Derived ring geometry for a block size write
	assign b_new    = (cfg_data[BS_W-1:0] == '0) ? BS_W'(1) : cfg_data[BS_W-1:0];
	assign ring_new = RING_W'(b_new) * BB_C;
	assign lim_new  = RING_W'(b_new) * BB_M1_C;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b_q         <= BS_RST;
			ring_q      <= RING_RST;
			lim_q       <= LIM_RST;
			ls_q        <= '0;
			le_q        <= '0;
			rem_start_q <= 1'b0;
		end else begin
			rem_start_q <= cfg_we && (cfg_index == REG_BLOCK_SIZE);
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BLOCK_SIZE: begin
						b_q    <= b_new;
						ring_q <= ring_new;
						lim_q  <= lim_new;
					end
					REG_LOOP_START: ls_q <= cfg_data;
					REG_LOOP_END:   le_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ch.ready) begin
			valid_s1 <= cmd_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ch.ready && cmd_ch.valid) begin
			cmd_s1     <= cmd_e'(cmd_ch.cmd);
			pc_s1      <= cmd_ch.play_cursor;
			restart_s1 <= cmd_ch.restart;
			lreq_s1    <= cmd_ch.loop_request;
			sb_s1      <= cmd_ch.start_byte;
		end
	end

	// Decide what the command does
	always_comb begin
		do_restart = (cmd_s1 == CMD_PLAY) && restart_s1;
		ticking    = (cmd_s1 == CMD_TICK) && playing_q;
		drain      = ticking && ended_q && (pc_s1 > wc_q) &&
			((pc_s1 - wc_q) < OFF_W'(b_q));
		trig       = ({1'b0, pc_s1} > ({1'b0, wc_q} + (OFF_W + 1)'(b_q))) ||
			((pc_s1 < wc_q) && (CW'(wc_q) >= CW'(lim_q)));
		do_refill  = do_restart || (ticking && !ended_q && trig);
	end

	// Refill region: whole ring from offset zero, or one block at the write cursor
	always_comb begin
		at_off = do_restart ? '0 : wc_q;
		at_mod = do_restart ? '0 : wm_q;
		len    = do_restart ? ring_q : RING_W'(b_q);
		sp     = do_restart ? sb_s1 : sp_q;
		loop   = do_restart ? lreq_s1 : looping_q;

		// Split at loop end
		over = ({1'b0, sp} + (SRC_W + 1)'(len)) > {1'b0, le_q};
		t32  = (sp < le_q) ? (le_q - sp) : '0;
		t_r  = RING_W'(t32);
		rest = len - t_r;

		// Second segment offset wraps modulo the ring
		sec_sum = (RING_W + 1)'(at_mod) + (RING_W + 1)'(t_r);
		sec     = (sec_sum >= {1'b0, ring_q}) ? (sec_sum - {1'b0, ring_q}) : sec_sum;

		// Write cursor advance
		nsum    = (RING_W + 1)'(wm_q) + (RING_W + 1)'(b_q);
		nred    = (nsum >= {1'b0, ring_q}) ? (nsum - {1'b0, ring_q}) : nsum;
		wc_next = OFF_W'(nred);

		if (!over) begin
			sp_new = sp + SRC_W'(len);
		end else if (loop) begin
			sp_new = ls_q + SRC_W'(rest);
		end else begin
			sp_new = le_q;
		end
	end

	// Result segments
	always_comb begin
		push.r0.kind          = KIND_COPY;
		push.r0.buffer_offset = at_off;
		push.r0.source_offset = sp;
		push.r0.seg_length    = over ? OFF_W'(t_r) : OFF_W'(len);
		push.r0.last          = !over;
		if (drain) begin
			push.r0.kind          = KIND_STOP;
			push.r0.buffer_offset = wc_q;
			push.r0.source_offset = '0;
			push.r0.seg_length    = '0;
			push.r0.last          = 1'b1;
		end
		push.r1.kind          = loop ? KIND_COPY : KIND_SILENCE;
		push.r1.buffer_offset = OFF_W'(sec);
		push.r1.source_offset = loop ? ls_q : '0;
		push.r1.seg_length    = OFF_W'(rest);
		push.r1.last          = 1'b1;

		push.n = 2'd0;
		if (proc) begin
			if (drain) begin
				push.n = 2'd1;
			end else if (do_refill) begin
				push.n = over ? 2'd2 : 2'd1;
			end
		end
	end

	// Playback state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q      <= '0;
			wm_q      <= '0;
			sp_q      <= '0;
			playing_q <= 1'b0;
			looping_q <= 1'b0;
			ended_q   <= 1'b0;
		end else if (rem_st.done) begin
			wm_q <= rem_st.rem;
		end else if (proc) begin
			unique case (cmd_s1)
				CMD_PLAY: begin
					looping_q <= lreq_s1;
					playing_q <= 1'b1;
					ended_q   <= 1'b0;
					if (restart_s1) begin
						wc_q    <= '0;
						wm_q    <= '0;
						sp_q    <= sp_new;
						ended_q <= over && !lreq_s1;
					end
				end
				CMD_STOP: playing_q <= 1'b0;
				CMD_TICK: begin
					if (drain) begin
						playing_q <= 1'b0;
					end else if (do_refill) begin
						sp_q <= sp_new;
						wc_q <= wc_next;
						wm_q <= wc_next;
						if (over && !loop) begin
							ended_q <= 1'b1;
						end
					end
				end
				CMD_NONE: ;
				default: ;
			endcase
		end
	end

endmodule

### rtl/stream_ring_refill_controller_top.sv
`timescale 1ns / 1ps
// Top level of the stream ring refill controller: command register/core, remainder unit,
// result queue. Depends on srrc_pkg, srrc_if, srrc_core, srrc_rem and srrc_fifo.
//
// The controller accepts one command transaction every cycle while the result queue has room and
// no cursor reduction runs. Each command is decoded and executed in a single pass from the
// command register into a four-entry result queue, so the command register and then a queue
// entry lie between an accepted command and its first segment on the segment channel. A refill
// that crosses the loop end yields two segments, and the segment channel delivers one
// segment a cycle while seg_ch is ready, so a stream of such refills is paced by that channel.
// After each write of block_size the controller reduces the write cursor modulo the new ring
// size in a bit-serial remainder unit and holds cmd_ch.ready low while it runs; writes of the
// other registers cost nothing. The ring holds BUFFER_BLOCKS blocks.
module stream_ring_refill_controller_top import srrc_pkg::*; #(
	parameter int BUFFER_BLOCKS = BUFFER_BLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	srrc_cmd_if.sink         cmd_ch,
	srrc_seg_if.source       seg_ch
);

	localparam int RING_W = BS_W + $clog2(BUFFER_BLOCKS);

	push_t             push;
	logic              room;
	logic              rem_start;
	logic [OFF_W-1:0]  rem_dividend;
	logic [RING_W-1:0] ring;
	rem_st_t           rem_st;

	srrc_core #(
		.BUFFER_BLOCKS(BUFFER_BLOCKS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.cmd_ch      (cmd_ch),
		.room        (room),
		.push        (push),
		.rem_start   (rem_start),
		.rem_dividend(rem_dividend),
		.ring        (ring),
		.rem_st      (rem_st)
	);

	srrc_rem #(
		.DIV_W(RING_W)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (rem_start),
		.dividend(rem_dividend),
		.divisor (ring),
		.st      (rem_st)
	);

	srrc_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.room  (room),
		.seg_ch(seg_ch)
	);

	// Queue never takes segments without room for a full pair
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> room)
		else $error("result push without queue room");

	// A split refill ends on its second segment only
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n == 2'd2) |-> (push.r1.last && !push.r0.last))
		else $error("split refill last flag wrong");

	// A block size write stalls commands while the cursor is reduced
	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_index == REG_BLOCK_SIZE)) |=> !cmd_ch.ready)
		else $error("command accepted right after block size write");

	a_rem_stall: assert property (@(posedge clk) disable iff (!arst_n)
		rem_st.busy |-> !cmd_ch.ready)
		else $error("command accepted during cursor reduction");

endmodule
